[rtl/smn_pkg.sv]
`timescale 1ns / 1ps

package smn_pkg;

  localparam int INDEX_W = 13;
  localparam int VALUE_W = 64;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [2:0]         mult_k_t;

  localparam mult_k_t MUL3 = 3'd3;
  localparam mult_k_t MUL5 = 3'd5;
  localparam mult_k_t MUL7 = 3'd7;

  localparam value_t SAT_VALUE = {VALUE_W{1'b1}};
  localparam value_t ONE_VALUE = value_t'(1);

endpackage

[rtl/smn_in_if.sv]
`timescale 1ns / 1ps

interface smn_in_if import smn_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

[rtl/smn_out_if.sv]
`timescale 1ns / 1ps

interface smn_out_if import smn_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

[rtl/smn_ram.sv]
`timescale 1ns / 1ps

module smn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/smn_alu.sv]
`timescale 1ns / 1ps

module smn_alu import smn_pkg::*; (
  input  value_t  v,
  input  mult_k_t k,
  output value_t  prod
);

  localparam int PW = VALUE_W + $bits(mult_k_t);

  logic [PW-1:0] full;

  assign full = PW'(v) * PW'(k);

  // saturate when the product leaves 64 bits
  assign prod = (full[PW-1:VALUE_W] != '0) ? SAT_VALUE : full[VALUE_W-1:0];

endmodule

[rtl/smooth_number_357_generator.sv]
`timescale 1ns / 1ps

// Returns the index-th number of the form 3^a*5^b*7^c in ascending order (index 0 gives 1),
// with overflow set and value all ones when the true number passes 64 bits; indexes of
// STORE_DEPTH or more read the last entry. Computed entries stay in an on-chip store across
// words, so a word whose entry already exists is read straight from the store (the first word
// after reset also writes entry 0 first), and a word that extends the store computes each
// missing entry in turn, up to the one it asks for. Each new entry needs three reads of the
// store and three passes through the one shared saturating multiplier. No clearing pass runs
// after reset. One word is worked on at a time; a finished result waits in an output register
// while the next word is accepted.
module smooth_number_357_generator import smn_pkg::*; #(
  parameter int STORE_DEPTH = 8192
) (
  input logic      clk,
  input logic      rst,
  smn_in_if.sink   req,
  smn_out_if.source rsp
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = AW + 1;
  localparam int NW = (CW > INDEX_W) ? CW : INDEX_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_RD3 = 4'd3;
  localparam logic [3:0] S_RD5 = 4'd4;
  localparam logic [3:0] S_RD7 = 4'd5;
  localparam logic [3:0] S_C7 = 4'd6;
  localparam logic [3:0] S_MIN = 4'd7;
  localparam logic [3:0] S_WR = 4'd8;
  localparam logic [3:0] S_RDF = 4'd9;
  localparam logic [3:0] S_FIN = 4'd10;

  logic [3:0]    state;
  logic [AW-1:0] p3;
  logic [AW-1:0] p5;
  logic [AW-1:0] p7;
  logic [CW-1:0] fill;
  logic [AW-1:0] n;
  value_t        c3;
  value_t        c5;
  value_t        c7;
  value_t        least;
  value_t        rsp_value;
  logic          rsp_overflow;
  logic          rsp_valid;

  logic [NW-1:0] idx_ext;
  logic [AW-1:0] n_in;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  value_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  value_t        ram_rdata;
  mult_k_t       alu_k;
  value_t        alu_prod;

  assign idx_ext = NW'(req.index);
  assign n_in = (idx_ext >= NW'(STORE_DEPTH)) ? AW'(STORE_DEPTH - 1) : idx_ext[AW-1:0];

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.value = rsp_value;
  assign rsp.overflow = rsp_overflow;

  smn_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smn_alu u_alu (
    .v    (ram_rdata),
    .k    (alu_k),
    .prod (alu_prod)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = fill[AW-1:0];
    ram_wdata = least;
    ram_raddr = n;
    alu_k = MUL3;
    case (state)
      S_INIT: begin
        ram_we = 1'b1;
        ram_waddr = '0;
        ram_wdata = ONE_VALUE;
      end
      S_RD3: begin
        ram_raddr = p3;
      end
      S_RD5: begin
        ram_raddr = p5;
        alu_k = MUL3;
      end
      S_RD7: begin
        ram_raddr = p7;
        alu_k = MUL5;
      end
      S_C7: begin
        alu_k = MUL7;
      end
      S_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p3 <= '0;
      p5 <= '0;
      p7 <= '0;
      fill <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            n <= n_in;
            state <= (fill == '0) ? S_INIT : S_CHECK;
          end
        end
        S_INIT: begin
          fill <= CW'(1);
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= (CW'(n) >= fill) ? S_RD3 : S_RDF;
        end
        S_RD3: begin
          state <= S_RD5;
        end
        S_RD5: begin
          c3 <= alu_prod;
          state <= S_RD7;
        end
        S_RD7: begin
          c5 <= alu_prod;
          least <= c3;
          state <= S_C7;
        end
        S_C7: begin
          c7 <= alu_prod;
          least <= (c5 < least) ? c5 : least;
          state <= S_MIN;
        end
        S_MIN: begin
          least <= (c7 < least) ? c7 : least;
          state <= S_WR;
        end
        S_WR: begin
          fill <= fill + CW'(1);
          if (c3 == least) begin
            p3 <= p3 + AW'(1);
          end
          if (c5 == least) begin
            p5 <= p5 + AW'(1);
          end
          if (c7 == least) begin
            p7 <= p7 + AW'(1);
          end
          state <= (CW'(n) > fill) ? S_RD3 : S_RDF;
        end
        S_RDF: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_value <= ram_rdata;
            rsp_overflow <= (ram_rdata == SAT_VALUE);
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/smooth_number_357_generator_tb.sv]
`timescale 1ns / 1ps

module smooth_number_357_generator_tb;
  import smn_pkg::*;

  localparam int STORE_DEPTH  = 8192;
  localparam int RANDOM_WORDS = 80;
  localparam int CALM_TAIL    = 15;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PROBE_COUNT  = 20;

  typedef struct packed {
    value_t value;
    logic   overflow;
  } result_t;

  typedef struct packed {
    index_t  index;
    logic    fixed;
    result_t result;
  } probe_t;

  bit   clk = 1'b0;
  logic rst;

  smn_in_if  req ();
  smn_out_if rsp ();

  smooth_number_357_generator #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  probe_t probe_rows [PROBE_COUNT] = '{
    '{index_t'(0),    1'b1, '{ONE_VALUE, 1'b0}},
    '{index_t'(1),    1'b1, '{value_t'(3), 1'b0}},
    '{index_t'(2),    1'b1, '{value_t'(5), 1'b0}},
    '{index_t'(3),    1'b1, '{value_t'(7), 1'b0}},
    '{index_t'(4),    1'b0, '0},
    '{index_t'(14),   1'b0, '0},
    '{index_t'(12),   1'b0, '0},
    '{index_t'(63),   1'b0, '0},
    '{index_t'(1000), 1'b0, '0},
    '{index_t'(2730), 1'b0, '0},
    '{index_t'(4096), 1'b0, '0},
    '{index_t'(4800), 1'b0, '0},
    '{index_t'(4900), 1'b0, '0},
    '{index_t'(5000), 1'b0, '0},
    '{index_t'(5100), 1'b0, '0},
    '{index_t'(5200), 1'b0, '0},
    '{index_t'(5461), 1'b0, '0},
    '{index_t'(8190), 1'b0, '0},
    '{index_t'(8191), 1'b1, '{SAT_VALUE, 1'b1}},
    '{index_t'(0),    1'b1, '{ONE_VALUE, 1'b0}}
  };

  value_t      smooth_store [STORE_DEPTH];
  int unsigned ptr3, ptr5, ptr7, stored;

  result_t     pending_results [$];
  int unsigned words_sent, results_checked, saturated_seen, mismatches, cycle_count;
  bit          calm, hold_request, hold_done;

  function automatic value_t sat_times(value_t v, mult_k_t k);
    logic [VALUE_W+2:0] prod;
    prod = {3'b000, v} * k;
    return (prod[VALUE_W+2:VALUE_W] != 3'b000) ? SAT_VALUE : prod[VALUE_W-1:0];
  endfunction

  function automatic value_t store_entry(int unsigned p);
    return (p >= STORE_DEPTH) ? SAT_VALUE : smooth_store[p];
  endfunction

  function automatic result_t predict_smooth(index_t index);
    int unsigned n;
    value_t      c3, c5, c7, least;
    n = (index >= STORE_DEPTH) ? STORE_DEPTH - 1 : index;
    if (stored == 0) begin
      smooth_store[0] = ONE_VALUE;
      stored = 1;
    end
    while (stored <= n && stored < STORE_DEPTH) begin
      c3 = sat_times(store_entry(ptr3), MUL3);
      c5 = sat_times(store_entry(ptr5), MUL5);
      c7 = sat_times(store_entry(ptr7), MUL7);
      least = c3;
      if (c5 < least) least = c5;
      if (c7 < least) least = c7;
      smooth_store[stored] = least;
      stored++;
      if (c3 == least) ptr3++;
      if (c5 == least) ptr5++;
      if (c7 == least) ptr7++;
    end
    return '{smooth_store[n], smooth_store[n] == SAT_VALUE};
  endfunction

  task automatic offer_word(input index_t index, input bit fixed, input result_t typed);
    result_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.index <= index;
    do @(posedge clk); while (!req.ready);
    predicted = predict_smooth(index);
    pending_results.push_back(fixed ? typed : predicted);
    words_sent++;
  endtask

  initial begin
    index_t      pick;
    int unsigned i, roll;
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.index <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < PROBE_COUNT; i++)
      offer_word(probe_rows[i].index, probe_rows[i].fixed, probe_rows[i].result);
    for (i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 60 && i < 70) || (i >= RANDOM_WORDS - CALM_TAIL);
      if (i == 30) hold_request = 1'b1;
      roll = $urandom_range(0, 9);
      if (roll < 5)      pick = index_t'($urandom_range(0, 63));
      else if (roll < 7) pick = index_t'($urandom_range(4000, 6000));
      else               pick = index_t'($urandom_range(0, 8191));
      offer_word(pick, 1'b0, '0);
    end
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d words sent, %0d results checked (%0d saturated), store reached %0d entries",
             words_sent, results_checked, saturated_seen, stored);
    $display("output held off %0d cycles once under load; %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0)
      $display("smooth_number_357_generator_tb OK");
    else
      $display("smooth_number_357_generator_tb NOT OK");
    $finish;
  end

  initial begin
    rsp.ready <= 1'b0;
    repeat (5) @(posedge clk);
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp.ready <= 1'b1;
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %h overflow %b", rsp.value, rsp.overflow);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.overflow) saturated_seen++;
        if (rsp.value !== want.value || rsp.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: expected value %h overflow %b, got %h %b",
                     results_checked, want.value, want.overflow, rsp.value, rsp.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("smooth_number_357_generator_tb NOT OK");
      $finish;
    end
  end

endmodule
